/* design/uigfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uigfr_pkg - shared definitions for the idle-gap frame ring
// Operation codes, register indexes, reset values and default geometry.
// ----------------------------------------------------------------------------
package uigfr_pkg;

  localparam int unsigned LinesDef     = 4;
  localparam int unsigned LineBytesDef = 32;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TickW    = 16;

  localparam logic [CfgIdxW-1:0] RegGapTicks   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegErrorTicks = 1'd1;

  localparam logic [TickW-1:0] GapTicksRst   = 16'd2;
  localparam logic [TickW-1:0] ErrorTicksRst = 16'd200;
  localparam logic [TickW-1:0] IdleMax       = 16'hFFFF;

  typedef enum logic [1:0] {
    OpRxByte  = 2'd0,
    OpTick    = 2'd1,
    OpRead    = 2'd2,
    OpRelease = 2'd3
  } op_e;

endpackage : uigfr_pkg
`default_nettype wire

/* design/uart_idle_gap_frame_ring.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uart_idle_gap_frame_ring - receive buffer delimiting frames by idle gaps
// Bytes go into a ring of frame lines; ticks close frames after a gap.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid_i/in_ready_o | op_i, rx_byte_i, offset_i
//  out      | out_valid_o/out_ready_i | read_data_o, frames_pending_o,
//           |                       | comm_error_o, frame_open_o
//  cfg      | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
//  One word per cycle unless a held result stalls input; each result appears in the cycle after its word is taken.
//  The frame memory is read once per word and written only for received bytes, read data registered.
//  A held result stalls input only while out_ready_i is low.
//  Reset clears control state and loads config reset values; the frame memory is left undefined.
// ----------------------------------------------------------------------------
module uart_idle_gap_frame_ring
  import uigfr_pkg::*;
#(
  parameter int unsigned LINES      = LinesDef,
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [4:0]          offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               read_data_o,
  output logic [2:0]               frames_pending_o,
  output logic                     comm_error_o,
  output logic                     frame_open_o
);

  localparam int unsigned Depth = LINES * LINE_BYTES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned PW    = $clog2(LINE_BYTES + 1);
  localparam int unsigned UW    = $clog2(LINES + 1);

  localparam logic [LW-1:0] LastLine = LW'(LINES - 1);
  localparam logic [PW-1:0] LastPos  = PW'(LINE_BYTES - 1);
  localparam logic [PW-1:0] FullPos  = PW'(LINE_BYTES);
  localparam logic [UW-1:0] FullUsed = UW'(LINES);

  logic [7:0] mem_q [Depth];

  logic [TickW-1:0] gap_ticks_q, error_ticks_q;
  logic [LW-1:0]    write_line_q, write_line_d, read_line_q, read_line_d;
  logic [PW-1:0]    write_pos_q, write_pos_d, wr_slot;
  logic [UW-1:0]    used_q, used_d;
  logic [TickW-1:0] idle_q, idle_d;
  logic             open_q, open_d, error_q, error_d;
  logic             out_valid_q, rd_sel_q, rd_sel_d;
  logic [7:0]       rd_q;
  logic             accept, wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  op_e              op;

  assign op         = op_e'(op_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    write_line_d = write_line_q;
    write_pos_d  = write_pos_q;
    read_line_d  = read_line_q;
    used_d       = used_q;
    idle_d       = idle_q;
    open_d       = open_q;
    error_d      = error_q;
    rd_sel_d     = 1'b0;
    wr_en        = 1'b0;
    wr_slot      = (write_pos_q >= FullPos) ? LastPos : write_pos_q;
    case (op)
      OpRxByte: begin
        idle_d      = '0;
        open_d      = 1'b1;
        wr_en       = 1'b1;
        write_pos_d = wr_slot + PW'(1);
      end
      OpTick: begin
        if (idle_q != IdleMax) idle_d = idle_q + TickW'(1);
        if (open_q && (idle_d >= gap_ticks_q)) begin
          open_d = 1'b0;
          if (used_q < FullUsed) begin
            used_d       = used_q + UW'(1);
            write_line_d = (write_line_q == LastLine) ? '0 : write_line_q + LW'(1);
            write_pos_d  = '0;
          end
        end
        error_d = (idle_d >= error_ticks_q);
      end
      OpRead: begin
        rd_sel_d = (32'(offset_i) < LINE_BYTES);
      end
      OpRelease: begin
        if (used_q != '0) begin
          used_d      = used_q - UW'(1);
          read_line_d = (read_line_q == LastLine) ? '0 : read_line_q + LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = AW'(32'(write_line_q) * LINE_BYTES + 32'(wr_slot));
  assign rd_addr = AW'(32'(read_line_q) * LINE_BYTES + 32'(offset_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q   <= GapTicksRst;
      error_ticks_q <= ErrorTicksRst;
      write_line_q  <= '0;
      write_pos_q   <= '0;
      read_line_q   <= '0;
      used_q        <= '0;
      idle_q        <= '0;
      open_q        <= 1'b0;
      error_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      rd_sel_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGapTicks:   gap_ticks_q   <= cfg_wdata_i;
          RegErrorTicks: error_ticks_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (accept) begin
        write_line_q <= write_line_d;
        write_pos_q  <= write_pos_d;
        read_line_q  <= read_line_d;
        used_q       <= used_d;
        idle_q       <= idle_d;
        open_q       <= open_d;
        error_q      <= error_d;
        rd_sel_q     <= rd_sel_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame memory: one registered read per word, a write only for received bytes
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) mem_q[wr_addr] <= rx_byte_i;
    if (accept) rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rd_sel_q ? rd_q : 8'd0;
  assign frames_pending_o = 3'(used_q);
  assign comm_error_o     = error_q;
  assign frame_open_o     = open_q;

endmodule : uart_idle_gap_frame_ring
`default_nettype wire
